### sv/vwf_pkg.sv
package vwf_pkg;

    localparam int TableDepth = 256;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = IdxW + 1;

    localparam logic [1:0] KIND_NEW  = 2'd0;
    localparam logic [1:0] KIND_IDX  = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    localparam logic [1:0] REG_FAN_MODE  = 2'd0;
    localparam logic [1:0] REG_USE_NORM  = 2'd1;
    localparam logic [1:0] REG_USE_TEX   = 2'd2;
    localparam logic [1:0] REG_THRESHOLD = 2'd3;

    localparam logic [31:0] THRESHOLD_RESET = 32'd4295;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               polygon_start;
        logic               batch_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] vertex_index;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    // squared distance term of one component, saturated at 2^32
    function automatic logic [32:0] sq_term(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        logic        [32:0] ad;
        logic        [31:0] p;
        begin
            d  = {a[31], a} - {b[31], b};
            ad = d[32] ? 33'(-d) : 33'(d);
            p  = 32'(ad[15:0]) * 32'(ad[15:0]);
            sq_term = (ad >= 33'd65536) ? 33'h1_0000_0000 : {1'b0, p};
        end
    endfunction

endpackage

### sv/vertex_weld_fan_indexer.sv
// Search: a new vertex is compared with each stored entry in turn, and a match ends the search
// early. Its results are then emitted one at a time, each held until the receiver takes it.
// Throughput: one item at a time; set by the single shared squared-distance unit that
// walks the table one component per cycle, one memory read per entry.
// Reset (synchronous, active low) clears the count, fan state, state machine and configuration registers.
module vertex_weld_fan_indexer
    import vwf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [255:0]    mem [TableDepth];
    logic [255:0]    r_rd;
    t_state          r_state, n_state;
    t_in_item        r_in;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] r_ptr;
    logic [2:0]      r_comp;
    logic            r_ok;
    logic            r_found;
    logic [7:0]      r_first, r_prev, r_idx;
    logic [1:0]      r_pvc;
    logic            r_fan, r_unorm, r_utex;
    logic [31:0]     r_thr;
    t_out_item       r_res [4];
    logic [2:0]      r_nres, r_ores;

    logic [255:0] in_vec;
    logic [31:0]  ca, cb;
    logic         le, grp_end, comp_use, clr, en;
    logic         entry_ok;

    assign in_vec = {r_in.pos_x, r_in.pos_y, r_in.pos_z, r_in.norm_x, r_in.norm_y,
                     r_in.norm_z, r_in.tex_u, r_in.tex_v};
    assign ca = in_vec[255 - 32*r_comp -: 32];
    assign cb = r_rd[255 - 32*r_comp -: 32];
    assign grp_end  = (r_comp == 3'd2) || (r_comp == 3'd5) || (r_comp == 3'd7);
    assign comp_use = (r_comp < 3'd3) || (r_comp < 3'd6 ? r_unorm : r_utex);
    assign en  = (r_state == ST_CMP);
    assign clr = (r_state != ST_CMP) || grp_end;
    assign entry_ok = r_ok && (!grp_end || !comp_use || le);

    vwf_dist u_dist (
        .i_clk       (i_clk),
        .i_clear     (clr && !(en && !grp_end)),
        .i_en        (en),
        .i_a         (ca),
        .i_b         (cb),
        .i_threshold (r_thr),
        .o_le        (le)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_READ;
            ST_READ:   n_state = (r_ptr < r_cnt) ? ST_CMP : ST_DECIDE;
            ST_CMP: begin
                if (r_comp == 3'd7) n_state = entry_ok ? ST_DECIDE : ST_READ;
            end
            ST_DECIDE: n_state = ST_EMIT;
            ST_EMIT:   if (i_ready && r_ores + 3'd1 >= r_nres) n_state = ST_IDLE;
                       else if (r_nres == 3'd0) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_EMIT) && (r_ores < r_nres);
        o_data  = r_res[r_ores[1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) r_rd <= mem[r_ptr[IdxW-1:0]];
        if (r_state == ST_DECIDE && !r_found && r_cnt < CntW'(TableDepth))
            mem[r_cnt[IdxW-1:0]] <= in_vec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0; r_first <= '0; r_prev <= '0; r_pvc <= '0;
            r_fan <= 1'b0; r_unorm <= 1'b0; r_utex <= 1'b0;
            r_thr <= THRESHOLD_RESET;
            r_nres <= '0; r_ores <= '0; r_found <= 1'b0;
            r_ptr <= '0; r_comp <= '0; r_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FAN_MODE:  r_fan   <= i_cfg_data[0];
                    REG_USE_NORM:  r_unorm <= i_cfg_data[0];
                    REG_USE_TEX:   r_utex  <= i_cfg_data[0];
                    REG_THRESHOLD: r_thr   <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_in <= i_data;
                    r_ptr <= '0; r_found <= 1'b0; r_ores <= '0; r_nres <= '0;
                    if (i_data.batch_start) begin
                        r_cnt <= '0; r_first <= '0; r_prev <= '0; r_pvc <= '0;
                    end
                end
                ST_READ: begin
                    r_comp <= '0; r_ok <= 1'b1;
                end
                ST_CMP: begin
                    r_ok <= entry_ok;
                    r_comp <= r_comp + 3'd1;
                    if (r_comp == 3'd7) begin
                        if (entry_ok) begin
                            r_found <= 1'b1;
                            r_idx <= 8'(r_ptr);
                        end else begin
                            r_ptr <= r_ptr + 1'b1;
                        end
                    end
                end
                ST_DECIDE: begin : dec
                    logic [7:0] id;
                    logic [2:0] n;
                    logic       pnew;
                    logic       more;
                    id = r_found ? r_idx : 8'(r_cnt);
                    n = 3'd0;
                    pnew = r_in.polygon_start ? 1'b1 : 1'b0;
                    // fan results follow only from the third vertex of a polygon on
                    more = !r_fan || (!pnew && r_pvc == 2'd2);
                    if (!r_found && r_cnt >= CntW'(TableDepth)) begin
                        r_res[0] <= '{kind: KIND_FULL, vertex_index: 8'd0, last: 1'b1};
                        n = 3'd1;
                    end else begin
                        if (!r_found) begin
                            r_cnt <= r_cnt + 1'b1;
                            r_res[0] <= '{kind: KIND_NEW, vertex_index: id, last: !more};
                            n = 3'd1;
                        end
                        if (!r_fan) begin
                            r_res[n[1:0]] <= '{kind: KIND_IDX, vertex_index: id, last: 1'b1};
                            n = n + 3'd1;
                        end else if (pnew || r_pvc == 2'd0) begin
                            r_first <= id; r_prev <= id; r_pvc <= 2'd1;
                        end else if (r_pvc == 2'd1) begin
                            r_prev <= id; r_pvc <= 2'd2;
                        end else begin
                            r_res[n[1:0]] <= '{kind: KIND_IDX, vertex_index: r_first, last: 1'b0};
                            r_res[2'(n + 3'd1)] <= '{kind: KIND_IDX, vertex_index: r_prev,
                                                     last: 1'b0};
                            r_res[2'(n + 3'd2)] <= '{kind: KIND_IDX, vertex_index: id,
                                                     last: 1'b1};
                            n = n + 3'd3;
                            r_prev <= id;
                        end
                    end
                    r_nres <= n;
                end
                ST_EMIT: if (o_valid && i_ready) r_ores <= r_ores + 3'd1;
                default: ;
            endcase
        end
    end
endmodule

### sv/vwf_dist.sv
// One shared component unit: one squared term per cycle while enabled, accumulated per group.
module vwf_dist
    import vwf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_clear,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_threshold,
    output logic        o_le
);
    logic [34:0] r_sum;
    logic [34:0] n_sum;

    assign n_sum = r_sum + 35'(sq_term(i_a, i_b));

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_sum <= '0;
        end else if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_le = (n_sum <= 35'(i_threshold));
endmodule

### dv/weld_index_checker.sv
module weld_index_checker
    import vwf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] weld_table [TableDepth][8];
    int unsigned        weld_count;
    logic [7:0]         fan_first;
    logic [7:0]         fan_prev;
    int                 poly_seen;
    logic               fan_mode;
    logic               use_norm;
    logic               use_tex;
    logic [31:0]        threshold;
    t_out_item          index_q[$];

    initial begin
        o_fail_count   = 0;
        o_results_seen = 0;
        o_pending      = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // squared difference of one component, saturated at 2^32
    function automatic longint unsigned sq_diff(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return (d >= 65536) ? 64'h1_0000_0000 : longint'(d * d);
    endfunction

    function automatic bit near(input logic signed [31:0] v[8], input int ent,
                                input int from, input int n);
        longint unsigned sum;
        sum = 0;
        for (int k = from; k < from + n; k++) sum += sq_diff(v[k], weld_table[ent][k]);
        return sum <= {32'b0, threshold};
    endfunction

    task automatic push_index(input logic [1:0] kind, input int unsigned idx);
        t_out_item r;
        r.kind         = kind;
        r.vertex_index = idx[7:0];
        r.last         = 1'b0;
        index_q = {index_q, r};
    endtask

    task automatic predict_vertex(input t_in_item it);
        logic signed [31:0] v[8];
        int                 hit;
        int                 n0;
        n0 = index_q.size();
        v = '{it.pos_x, it.pos_y, it.pos_z, it.norm_x, it.norm_y, it.norm_z,
              it.tex_u, it.tex_v};
        if (it.batch_start) begin
            weld_count = 0;
            fan_first  = '0;
            fan_prev   = '0;
            poly_seen  = 0;
        end
        hit = -1;
        for (int e = 0; e < int'(weld_count) && hit < 0; e++) begin
            if (near(v, e, 0, 3) && (!use_norm || near(v, e, 3, 3))
                && (!use_tex || near(v, e, 6, 2)))
                hit = e;
        end
        if (hit < 0) begin
            if (weld_count >= TableDepth) begin
                push_index(KIND_FULL, 0);
                index_q[$].last = 1'b1;
                return;
            end
            hit = weld_count;
            weld_table[hit] = v;
            weld_count++;
            push_index(KIND_NEW, hit);
        end
        if (!fan_mode) begin
            push_index(KIND_IDX, hit);
        end else begin
            if (it.polygon_start) poly_seen = 0;
            if (poly_seen == 0) begin
                fan_first = hit[7:0];
                fan_prev  = hit[7:0];
                poly_seen = 1;
            end else if (poly_seen == 1) begin
                fan_prev  = hit[7:0];
                poly_seen = 2;
            end else begin
                push_index(KIND_IDX, fan_first);
                push_index(KIND_IDX, fan_prev);
                push_index(KIND_IDX, hit);
                fan_prev = hit[7:0];
            end
        end
        if (index_q.size() > n0) index_q[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            weld_count = 0;
            fan_first  = '0;
            fan_prev   = '0;
            poly_seen  = 0;
            fan_mode   = 1'b0;
            use_norm   = 1'b0;
            use_tex    = 1'b0;
            threshold  = THRESHOLD_RESET;
            index_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FAN_MODE:  fan_mode  = i_cfg_data[0];
                    REG_USE_NORM:  use_norm  = i_cfg_data[0];
                    REG_USE_TEX:   use_tex   = i_cfg_data[0];
                    REG_THRESHOLD: threshold = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_vertex(i_in_data);
            if (i_out_valid && i_out_ready) begin
                o_results_seen++;
                if (index_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind=%0d idx=%0d last=%0b",
                        i_out_data.kind, i_out_data.vertex_index, i_out_data.last));
                end else begin
                    want = index_q.pop_front();
                    if (i_out_data.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                            i_out_data.kind, want.kind));
                    if (i_out_data.vertex_index !== want.vertex_index)
                        report_mismatch($sformatf("vertex_index %0d, expected %0d",
                            i_out_data.vertex_index, want.vertex_index));
                    if (i_out_data.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                            i_out_data.last, want.last));
                end
            end
        end
        o_pending = index_q.size();
    end

endmodule

### dv/tb_vertex_weld_fan_indexer.sv
module tb_vertex_weld_fan_indexer;
    import vwf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DrainCycles = 9 * TableDepth + 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_FAN_MODE;
    logic [31:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int results_seen;
    int items_sent = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;
    t_in_item anchors[6];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vertex_weld_fan_indexer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    weld_index_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial begin
        #40ms;
        $display("Timeout with %0d results outstanding", pending);
        $display("Verification failed");
        $finish;
    end

    // receiver: modes of full speed, random stalls and a fixed pattern, plus a long hold-off
    initial begin
        int mode;
        int hold_cnt;
        hold_cnt = 0;
        mode     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = 600;
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 9) > 3);
                    default: i_ready <= (($time / 10) % 5) != 2;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // hold the item until taken; keep valid high inside a burst, drop it for a gap
    task automatic send_vertex(input t_in_item it);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        burst_left--;
        if (burst_left == 0) i_valid <= 1'b0;
    endtask

    task automatic settle();
        if (i_valid) begin
            i_valid <= 1'b0;
            burst_left = 0;
        end
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic t_in_item rand_vertex();
        t_in_item v;
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, 2'($urandom)};
        return v;
    endfunction

    function automatic logic signed [31:0] jit(input logic signed [31:0] c, input int span);
        return c + $signed(32'($urandom_range(0, 2 * span))) - span;
    endfunction

    // mostly near-copies of a few anchors so welding actually happens
    function automatic t_in_item near_vertex();
        t_in_item v;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3) return rand_vertex();
        v = anchors[$urandom_range(0, 5)];
        if (pick < 14) begin
            v.pos_x  = jit(v.pos_x, 80);
            v.pos_y  = jit(v.pos_y, 40);
            v.pos_z  = jit(v.pos_z, 40);
            v.norm_x = jit(v.norm_x, 70);
            v.norm_y = jit(v.norm_y, 70);
            v.norm_z = jit(v.norm_z, 70);
            v.tex_u  = jit(v.tex_u, 90);
            v.tex_v  = jit(v.tex_v, 90);
        end
        v.polygon_start = 1'b0;
        v.batch_start   = ($urandom_range(0, 39) == 0);
        return v;
    endfunction

    task automatic random_polygons(input int count);
        t_in_item v;
        int len;
        while (count > 0) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len && count > 0; k++) begin
                v = near_vertex();
                v.polygon_start = (k == 0) ? ($urandom_range(0, 9) != 0)
                                           : ($urandom_range(0, 14) == 0);
                send_vertex(v);
                count--;
            end
        end
    endtask

    initial begin
        t_in_item v;
        t_in_item a;
        logic [31:0] thr_set[5];
        logic        fan_set[5];
        logic        norm_set[5];
        logic        tex_set[5];

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // list mode at reset settings: extremes, exact repeat, threshold edge
        a = '0;
        a.batch_start = 1'b1;
        send_vertex(a);
        a.batch_start = 1'b0;
        send_vertex(a);
        v = '1;
        v.pos_x = 32'sh7FFF_FFFF; v.pos_y = 32'sh7FFF_FFFF; v.pos_z = 32'sh7FFF_FFFF;
        send_vertex(v);
        v.pos_x = 32'sh8000_0000; v.pos_y = 32'sh8000_0000; v.pos_z = 32'sh8000_0000;
        send_vertex(v);
        v = a;
        v.pos_x = 65;
        send_vertex(v);
        v.pos_x = -66;
        send_vertex(v);
        v.norm_x = 32'sh7FFF_FFFF; v.tex_v = 32'sh8000_0000; v.pos_x = 0;
        send_vertex(v);
        settle();

        write_reg(REG_FAN_MODE, 1);
        write_reg(REG_USE_NORM, 1);
        write_reg(REG_USE_TEX, 1);

        // fan: a matched opener yields nothing, then one quad, a restart and a batch clear
        v = a;
        send_vertex(v);
        v.pos_y = 32'sh0001_0000;
        v.polygon_start = 1'b1;
        send_vertex(v);
        v.polygon_start = 1'b0;
        v.pos_x = 32'sh0001_0000;
        send_vertex(v);
        v.tex_u = 32'sh0000_0100;
        send_vertex(v);
        v.norm_z = 32'sh0000_0041;
        send_vertex(v);
        v = a;
        v.polygon_start = 1'b1;
        send_vertex(v);
        send_vertex(a);
        v.batch_start = 1'b1;
        v.polygon_start = 1'b0;
        send_vertex(v);
        send_vertex(a);
        send_vertex(a);
        settle();

        thr_set  = '{32'd0, 32'hFFFF_FFFF, $urandom_range(4000, 40000), THRESHOLD_RESET,
                     32'h0010_0000};
        fan_set  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        norm_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        tex_set  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
        for (int p = 0; p < 5; p++) begin
            write_reg(REG_FAN_MODE, {31'b0, fan_set[p]});
            write_reg(REG_USE_NORM, {31'b0, norm_set[p]});
            write_reg(REG_USE_TEX, {31'b0, tex_set[p]});
            write_reg(REG_THRESHOLD, thr_set[p]);
            foreach (anchors[k]) anchors[k] = rand_vertex();
            if (p == 2) hold_req = 1'b1;
            random_polygons(40);
            settle();
        end

        // fill the table to capacity and past it, then revisit a stored vertex
        write_reg(REG_FAN_MODE, 0);
        write_reg(REG_USE_NORM, 1);
        write_reg(REG_USE_TEX, 1);
        write_reg(REG_THRESHOLD, 0);
        for (int k = 0; k < TableDepth + 3; k++) begin
            v = rand_vertex();
            v.batch_start = (k == 0);
            if (k == 1) a = v;
            send_vertex(v);
        end
        a.batch_start = 1'b0;
        send_vertex(a);
        settle();

        $display("Sent %0d vertices over list and fan modes, five threshold settings", items_sent);
        $display("Checked %0d index results, including a full table and a long output stall",
                 results_seen);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
